[rtl/core/fbfl_pkg.sv]
// ----------------------------------------------------------------------------
// fbfl_pkg: shared types and constants for the fixed block free list allocator
// Pool geometry, field widths, mode and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 48;
  localparam int LINES_MAX  = 1024;

  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINE_SHIFT = $clog2(LINE_BYTES);
  localparam int CNT_W      = 11;
  localparam int PROD_W     = 2 * CNT_W;
  localparam int STEP_W     = $clog2(IDX_W);
  localparam int OUT_W      = 72;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_REBUILD = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_LINES  = 2'd1;
  localparam logic [1:0] REG_ACTIVE = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] a;
    logic [ADDR_BITS-1:0] b;
    logic                 sub;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] sum;
    logic                 borrow;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_ADD,
    ST_FREE_SUB,
    ST_FREE_CMP,
    ST_FREE_DIV,
    ST_FREE_PUSH,
    ST_DONE
  } state_t;

endpackage

[rtl/core/fbfl_alu.sv]
// ----------------------------------------------------------------------------
// fbfl_alu: shared add/subtract unit
// One address-wide adder that the sequencer uses for address generation,
// bounds checks and every step of the block index division.
// ----------------------------------------------------------------------------
module fbfl_alu import fbfl_pkg::*; (
  input  alu_req_t req,
  output alu_res_t res
);

  logic [ADDR_BITS:0] total;

  // Subtraction is a + ~b + 1; a missing carry out means a borrow.
  assign total = {1'b0, req.a} + {1'b0, req.b ^ {ADDR_BITS{req.sub}}}
               + {{ADDR_BITS{1'b0}}, req.sub};

  assign res.sum    = total[ADDR_BITS-1:0];
  assign res.borrow = req.sub & ~total[ADDR_BITS];

endmodule

[rtl/core/fbfl_link_mem.sv]
// ----------------------------------------------------------------------------
// fbfl_link_mem: next-index memory of the free list
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module fbfl_link_mem import fbfl_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  link_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output link_t            rdata
);

  link_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/fixed_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator: LIFO free list over a pool of equal blocks
//
// Items arrive on the s_ stream: tuser carries the mode (allocate, free,
// rebuild) and tdata the byte address to free. Each item yields one result
// item on the m_ stream: tuser carries the status, tdata the allocated block
// address and the allocated and available counts.
// The cfg channel writes base address, block size in lines and pool size; it
// is always ready and should only be used while the block is idle.
// One item is worked on at a time. Allocate runs a memory read of the head
// entry, a multiply and an add from accept to result. Free runs a 10-step
// restoring division through the shared adder. Rebuild sweeps over all
// 1024 entries of the next-index memory at one entry per cycle.
// After reset the same sweep runs and no item is accepted until it ends.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a further result waits until it is taken.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator import fbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [ADDR_BITS-1:0] cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ADDR_BITS-1:0] s_tdata,  // address[47:0]
  input  logic [1:0]           s_tuser,  // mode[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,  // block_address[47:0], allocated[58:48],
                                         // available[69:59], zero[71:70]
  output logic [1:0]           m_tuser   // status[1:0]
);

  state_t state, state_next;

  logic [ADDR_BITS-1:0] cfg_base;
  logic [CNT_W-1:0]     cfg_lines;
  logic [CNT_W-1:0]     cfg_active;

  logic [ADDR_BITS-1:0] base_eff;
  logic [CNT_W-1:0]     lines_eff;
  logic [CNT_W-1:0]     active_eff;

  logic [IDX_W-1:0]     sweep_idx;
  logic                 sweep_last;
  logic                 sweep_reply;
  logic [IDX_W-1:0]     head;
  logic                 head_valid;
  logic [CNT_W-1:0]     allocated;
  logic [CNT_W-1:0]     available;
  logic [STEP_W-1:0]    step;

  logic [ADDR_BITS-1:0] oper_addr;
  logic [ADDR_BITS-1:0] offset;
  logic [PROD_W-1:0]    rem;
  logic [IDX_W-1:0]     quo;
  logic [PROD_W-1:0]    prod;
  logic [CNT_W-1:0]     mul_a;
  logic [ADDR_BITS-1:0] res_addr;
  logic [1:0]           res_status;
  logic                 out_load;

  logic [ADDR_BITS-1:0] prod_bytes;
  logic [ADDR_BITS-1:0] divisor;

  logic                 link_we;
  logic [IDX_W-1:0]     link_waddr;
  link_t                link_wdata;
  link_t                link_rdata;

  alu_req_t             alu_req;
  alu_res_t             alu_res;

  fbfl_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  fbfl_link_mem u_link_mem (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head),
    .rdata (link_rdata)
  );

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base   <= '0;
      cfg_lines  <= CNT_W'(1);
      cfg_active <= CNT_W'(MAX_BLOCKS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE:   cfg_base   <= cfg_data;
        REG_LINES:  cfg_lines  <= cfg_data[CNT_W-1:0];
        REG_ACTIVE: cfg_active <= cfg_data[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Out-of-range register values are clamped to the legal range; the base drops its line offset.
  always_comb begin
    base_eff = {cfg_base[ADDR_BITS-1:LINE_SHIFT], {LINE_SHIFT{1'b0}}};
    if (cfg_lines == '0) begin
      lines_eff = CNT_W'(1);
    end else if (cfg_lines > CNT_W'(LINES_MAX)) begin
      lines_eff = CNT_W'(LINES_MAX);
    end else begin
      lines_eff = cfg_lines;
    end
    if (cfg_active == '0) begin
      active_eff = CNT_W'(1);
    end else if (cfg_active > CNT_W'(MAX_BLOCKS)) begin
      active_eff = CNT_W'(MAX_BLOCKS);
    end else begin
      active_eff = cfg_active;
    end
  end

  assign sweep_last = (sweep_idx == IDX_W'(MAX_BLOCKS - 1));
  assign available  = (active_eff > allocated) ? active_eff - allocated : '0;
  assign out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);

  // The multiplier gives the block offset in lines while allocating and the
  // pool size in lines while freeing.
  assign mul_a      = (state == ST_ALLOC_RD) ? CNT_W'(head) : active_eff;
  assign prod_bytes = {{(ADDR_BITS - PROD_W - LINE_SHIFT){1'b0}}, prod,
                       {LINE_SHIFT{1'b0}}};
  assign divisor    = {{(ADDR_BITS - CNT_W){1'b0}}, lines_eff} << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    s_tready         = 1'b0;
    link_we          = 1'b0;
    link_waddr       = sweep_idx;
    link_wdata.valid = (sweep_idx != '0) && (CNT_W'(sweep_idx) < active_eff);
    link_wdata.idx   = link_wdata.valid ? sweep_idx - IDX_W'(1) : '0;
    alu_req.a        = oper_addr;
    alu_req.b        = base_eff;
    alu_req.sub      = 1'b1;
    unique case (state)
      ST_SWEEP: begin
        link_we = 1'b1;
        if (sweep_last) begin
          state_next = sweep_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (s_tuser)
            MODE_ALLOC:   state_next = head_valid ? ST_ALLOC_RD : ST_DONE;
            MODE_FREE:    state_next = ST_FREE_SUB;
            MODE_REBUILD: state_next = ST_SWEEP;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_ALLOC_RD: begin
        state_next = ST_ALLOC_ADD;
      end
      ST_ALLOC_ADD: begin
        alu_req.a   = base_eff;
        alu_req.b   = prod_bytes;
        alu_req.sub = 1'b0;
        state_next  = ST_DONE;
      end
      ST_FREE_SUB: begin
        state_next = alu_res.borrow ? ST_DONE : ST_FREE_CMP;
      end
      ST_FREE_CMP: begin
        alu_req.a  = offset;
        alu_req.b  = prod_bytes;
        state_next = alu_res.borrow ? ST_FREE_DIV : ST_DONE;
      end
      ST_FREE_DIV: begin
        alu_req.a = {{(ADDR_BITS - PROD_W){1'b0}}, rem};
        alu_req.b = divisor;
        if (step == '0) begin
          state_next = ST_FREE_PUSH;
        end
      end
      ST_FREE_PUSH: begin
        link_we          = 1'b1;
        link_waddr       = quo;
        link_wdata.valid = head_valid;
        link_wdata.idx   = head;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx   <= '0;
      sweep_reply <= 1'b0;
      head        <= '0;
      head_valid  <= 1'b0;
      allocated   <= '0;
      step        <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          sweep_idx <= sweep_idx + IDX_W'(1);
          if (sweep_last) begin
            head        <= IDX_W'(active_eff - CNT_W'(1));
            head_valid  <= 1'b1;
            allocated   <= '0;
            sweep_reply <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (s_tvalid && s_tuser == MODE_REBUILD) begin
            sweep_idx   <= '0;
            sweep_reply <= 1'b1;
          end
        end
        ST_ALLOC_ADD: begin
          head       <= link_rdata.idx;
          head_valid <= link_rdata.valid;
          if (allocated < CNT_W'(MAX_BLOCKS)) begin
            allocated <= allocated + CNT_W'(1);
          end
        end
        ST_FREE_CMP: begin
          step <= STEP_W'(IDX_W - 1);
        end
        ST_FREE_DIV: begin
          step <= step - STEP_W'(1);
        end
        ST_FREE_PUSH: begin
          head       <= quo;
          head_valid <= 1'b1;
          if (allocated != '0) begin
            allocated <= allocated - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(lines_eff);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          oper_addr  <= s_tdata;
          res_addr   <= '0;
          res_status <= (s_tuser == MODE_ALLOC && !head_valid) ? STATUS_EXHAUSTED
                                                               : STATUS_DONE;
        end
      end
      ST_ALLOC_ADD: begin
        res_addr <= alu_res.sum;
      end
      ST_FREE_SUB: begin
        offset <= alu_res.sum;
        if (alu_res.borrow) begin
          res_status <= STATUS_OUTSIDE;
        end
      end
      ST_FREE_CMP: begin
        // The offset is used only if it is below the pool size, so its whole lines fit.
        if (!alu_res.borrow) begin
          res_status <= STATUS_OUTSIDE;
        end
        rem <= offset[LINE_SHIFT +: PROD_W];
        quo <= '0;
      end
      ST_FREE_DIV: begin
        if (!alu_res.borrow) begin
          rem       <= alu_res.sum[PROD_W-1:0];
          quo[step] <= 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          m_tdata <= {{(OUT_W - ADDR_BITS - 2 * CNT_W){1'b0}}, available, allocated,
                      res_addr};
          m_tuser <= res_status;
        end
      end
      default: ;
    endcase
  end

  // A taken item keeps the input side closed for at least the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready
  ) else $error("input accepted twice in a row");

  // The divider must land on a block inside the pool.
  a_quotient_in_pool: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_FREE_PUSH) |-> (CNT_W'(quo) < active_eff)
  ) else $error("freed block index outside the pool");

  // The end of a sweep leaves the top block of the pool at the head.
  a_sweep_head: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_SWEEP && sweep_last) |=>
      (head_valid && CNT_W'(head) == $past(active_eff) - CNT_W'(1) && allocated == '0)
  ) else $error("free list head wrong after rebuild");

  // Only a live head may be popped.
  a_pop_live_head: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_ALLOC_RD) |-> head_valid
  ) else $error("pop from an empty free list");

endmodule

[tb/fbfl_checker.sv]
// ----------------------------------------------------------------------------
// fbfl_checker: result predictor and scoreboard for the block free list
// Watches the configuration, request and result channels. Every accepted
// request runs through a local model of the free list, and every accepted
// result item is compared field by field with the oldest predicted grant.
// ----------------------------------------------------------------------------
module fbfl_checker import fbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [ADDR_BITS-1:0] cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [ADDR_BITS-1:0] s_tdata,   // address[47:0]
  input  logic [1:0]           s_tuser,   // mode[1:0]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OUT_W-1:0]     m_tdata,   // block_address[47:0], allocated[58:48],
                                          // available[69:59], zero[71:70]
  input  logic [1:0]           m_tuser,   // status[1:0]
  output int                   outstanding,
  output int                   fail_count
);

  typedef struct packed {
    logic [ADDR_BITS-1:0] block_addr;
    logic [1:0]           status;
    logic [CNT_W-1:0]     allocated;
    logic [CNT_W-1:0]     available;
  } grant_t;

  grant_t expected_grants[$];

  logic [ADDR_BITS-1:0] base_reg;
  logic [CNT_W-1:0]     lines_reg;
  logic [CNT_W-1:0]     active_reg;

  logic [IDX_W-1:0] link_idx [MAX_BLOCKS];
  logic             link_ok  [MAX_BLOCKS];
  logic [IDX_W-1:0] head_idx;
  logic             head_ok;
  int unsigned      alloc_cnt;

  // Zero reads as one and anything past the top reads as the top.
  function automatic int unsigned clamp_count(input logic [CNT_W-1:0] v,
                                              input int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  task automatic relink_pool();
    int unsigned n;
    n = clamp_count(active_reg, MAX_BLOCKS);
    for (int unsigned i = 0; i < MAX_BLOCKS; i++) begin
      link_ok[i]  = (i > 0) && (i < n);
      link_idx[i] = ((i > 0) && (i < n)) ? IDX_W'(i - 1) : '0;
    end
    head_idx  = IDX_W'(n - 1);
    head_ok   = 1'b1;
    alloc_cnt = 0;
  endtask

  task automatic predict_grant(input logic [1:0] mode, input logic [ADDR_BITS-1:0] addr);
    logic [63:0] base_eff;
    logic [63:0] blk;
    logic [63:0] pool_len;
    logic [63:0] offs;
    logic [63:0] sum;
    int unsigned act;
    int unsigned idx;
    grant_t      g;
    base_eff = {16'b0, base_reg} & ~64'(LINE_BYTES - 1);
    blk      = 64'(clamp_count(lines_reg, LINES_MAX)) * 64'(LINE_BYTES);
    act      = clamp_count(active_reg, MAX_BLOCKS);
    g        = '0;
    case (mode)
      MODE_ALLOC: begin
        if (head_ok) begin
          sum          = base_eff + 64'(head_idx) * blk;
          g.block_addr = sum[ADDR_BITS-1:0];
          idx          = 32'(head_idx);
          head_ok      = link_ok[idx];
          head_idx     = link_idx[idx];
          if (alloc_cnt < MAX_BLOCKS) alloc_cnt++;
        end else begin
          g.status = STATUS_EXHAUSTED;
        end
      end
      MODE_FREE: begin
        pool_len = blk * 64'(act);
        offs     = {16'b0, addr} - base_eff;
        if ({16'b0, addr} < base_eff || offs >= pool_len) begin
          g.status = STATUS_OUTSIDE;
        end else begin
          // Any byte inside a block frees the whole block.
          idx           = int'(offs / blk);
          link_idx[idx] = head_idx;
          link_ok[idx]  = head_ok;
          head_idx      = IDX_W'(idx);
          head_ok       = 1'b1;
          if (alloc_cnt > 0) alloc_cnt--;
        end
      end
      MODE_REBUILD: relink_pool();
      default: ;  // The spare mode code leaves everything as it is.
    endcase
    g.allocated = CNT_W'(alloc_cnt);
    g.available = (act > alloc_cnt) ? CNT_W'(act - alloc_cnt) : '0;
    expected_grants.push_back(g);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      base_reg   = '0;
      lines_reg  = CNT_W'(1);
      active_reg = CNT_W'(MAX_BLOCKS);
      relink_pool();
      expected_grants.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE:   base_reg   = cfg_data;
          REG_LINES:  lines_reg  = cfg_data[CNT_W-1:0];
          REG_ACTIVE: active_reg = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_grant(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_grants.size() == 0) begin
          $error("result item arrived with no request pending");
          fail_count++;
        end else begin
          g = expected_grants.pop_front();
          check_field("block_address", 64'(g.block_addr), 64'(m_tdata[47:0]));
          check_field("status", 64'(g.status), 64'(m_tuser));
          check_field("allocated", 64'(g.allocated), 64'(m_tdata[58:48]));
          check_field("available", 64'(g.available), 64'(m_tdata[69:59]));
        end
      end
    end
    outstanding <= expected_grants.size();
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the fixed block free list allocator
// Drives allocate, free and rebuild requests over several pool settings,
// with random gaps on both streams and one long output stall, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import fbfl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Long enough to outlast the rebuild that opens the first phase and then
  // back the block up behind a waiting result.
  localparam int HOLD_CYCLES = 2000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = REG_BASE;
  logic [ADDR_BITS-1:0] cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [ADDR_BITS-1:0] s_tdata   = '0;
  logic [1:0]           s_tuser   = MODE_ALLOC;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic [1:0]           m_tuser;

  int   outstanding;
  int   fail_count;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_armed  = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;

  // Effective pool geometry, kept here to aim free requests at the pool.
  logic [ADDR_BITS-1:0] cur_base = '0;
  int unsigned          cur_blk  = LINE_BYTES;
  int unsigned          cur_act  = MAX_BLOCKS;

  fixed_block_free_list_allocator i_dut (.*);

  fbfl_checker i_checker (.*);

  always #1 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off once armed.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      if (hold_left == 0) hold_done = 1'b1;
      m_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [ADDR_BITS-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic int unsigned clamp_count(input logic [CNT_W-1:0] v,
                                              input int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [ADDR_BITS-1:0] pool_address(input bit in_pool);
    logic [63:0] a;
    if (in_pool) begin
      a = {16'b0, cur_base} + 64'($urandom_range(cur_act - 1)) * 64'(cur_blk)
          + 64'($urandom_range(cur_blk - 1));
    end else if ($urandom_range(1) == 1) begin
      a = {16'b0, cur_base} - 64'(1) - 64'($urandom_range(255));
    end else begin
      a = {16'b0, cur_base} + 64'(cur_blk) * 64'(cur_act) + 64'($urandom_range(255));
    end
    return a[ADDR_BITS-1:0];
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [ADDR_BITS-1:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 44) send_item(MODE_ALLOC, rand48());
    else if (r < 80) send_item(MODE_FREE, pool_address(1'b1));
    else if (r < 92) send_item(MODE_FREE, pool_address(1'b0));
    else if (r < 96) send_item(MODE_FREE, rand48());
    else if (r < 98) send_item(MODE_UNUSED, rand48());
    else send_item(MODE_REBUILD, rand48());
  endtask

  // Drops the request stream and waits until every result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(input logic [ADDR_BITS-1:0] base,
                              input logic [CNT_W-1:0] lines,
                              input logic [CNT_W-1:0] active);
    write_reg(REG_BASE, base);
    write_reg(REG_LINES, ADDR_BITS'(lines));
    write_reg(REG_ACTIVE, ADDR_BITS'(active));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_base = base & ~ADDR_BITS'(LINE_BYTES - 1);
    cur_blk  = clamp_count(lines, LINES_MAX) * LINE_BYTES;
    cur_act  = clamp_count(active, MAX_BLOCKS);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 24;
    rx_idle_pct = 73;

    // Default pool: pops from the top block, frees at block edges and
    // outside the pool, count saturation at zero, the spare mode, rebuild.
    send_item(MODE_ALLOC, '0);
    send_item(MODE_ALLOC, '1);
    send_item(MODE_FREE, 48'h0000_0000_FFFF);
    send_item(MODE_FREE, '1);
    send_item(MODE_FREE, 48'h0000_0001_0000);
    send_item(MODE_FREE, '0);
    send_item(MODE_FREE, 48'h0000_0000_0040);
    send_item(MODE_UNUSED, '0);
    send_item(MODE_REBUILD, '0);
    drain();

    // Oversized registers clamp, the base drops its line offset and block
    // addresses wrap; the old chain stays until the rebuild.
    write_config('1, 11'd2047, 11'd2047);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, '0);
    send_item(MODE_FREE, 48'hFFFF_FFFF_FFC5);
    send_item(MODE_REBUILD, '0);
    send_item(MODE_ALLOC, '0);
    drain();

    // Zero registers act as a single one-line block.
    write_config(48'h0000_0000_1000, 11'd0, 11'd0);
    send_item(MODE_REBUILD, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, 48'h0000_0000_1000);
    send_item(MODE_FREE, 48'h0000_0000_0FFF);
    send_item(MODE_FREE, 48'h0000_0000_1040);
    drain();

    write_config(48'h002A_0000_0000, 11'd3, 11'd2);
    send_item(MODE_REBUILD, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_ALLOC, '0);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        tx_idle_pct = 24;
        rx_idle_pct = 73;
      end else if (p < 6) begin
        tx_idle_pct = 73;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: write_config(rand48(), CNT_W'($urandom_range(4, 1)), CNT_W'($urandom_range(8, 2)));
        1: write_config('1, CNT_W'(LINES_MAX), CNT_W'(MAX_BLOCKS));
        2: write_config(rand48(), '0, '0);
        3: write_config(rand48(), CNT_W'($urandom_range(16, 1)), CNT_W'($urandom_range(64, 1)));
        4: write_config('0, 11'd2047, 11'd1500);
        5: write_config(rand48(), CNT_W'($urandom_range(1024, 1)),
                        CNT_W'($urandom_range(1024, 1)));
        6: write_config(rand48(), 11'd1, 11'd3);
        default: write_config(rand48(), CNT_W'($urandom_range(8, 1)),
                              CNT_W'($urandom_range(32, 2)));
      endcase
      // The small first pool fills up behind the long result stall.
      if (p == 0) hold_armed = 1'b1;
      send_item(MODE_REBUILD, rand48());
      repeat (49) random_item();
      drain();
    end

    repeat (1100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_alu.sv
rtl/core/fbfl_link_mem.sv
rtl/core/fixed_block_free_list_allocator.sv
tb/fbfl_checker.sv
tb/tb_top.sv
